[design/max_abs_diff_two_subarrays_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the max_abs_diff_two_subarrays block.
// Each macro expands to one labeled concurrent assertion on aclk.
// ----------------------------------------------------------------------------
`ifndef MAX_ABS_DIFF_TWO_SUBARRAYS_DEFINES_SVH
`define MAX_ABS_DIFF_TWO_SUBARRAYS_DEFINES_SVH

// Same-cycle implication, disabled while aresetn is low.
`define MAD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while aresetn is low.
`define MAD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mad_pkg.sv]
// ----------------------------------------------------------------------------
// mad_pkg
// Payload types and fixed field widths of the two-subarray difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package mad_pkg;

    localparam int SAMPLE_FIELD_W  = 16;
    localparam int DIFF_FIELD_W    = 27;
    localparam int JOB_QUEUE_DEPTH = 2;

    typedef struct packed {
        logic signed [SAMPLE_FIELD_W-1:0] sample;
        logic                             last;
    } in_t;

    typedef struct packed {
        logic [DIFF_FIELD_W-1:0] best_difference;
        logic                    overflow;
    } out_t;

endpackage

`default_nettype wire

[design/max_abs_diff_two_subarrays.sv]
// ----------------------------------------------------------------------------
// max_abs_diff_two_subarrays
// Largest absolute difference between the sums of two non-overlapping
// contiguous subarrays of a sample array, found with forward and backward
// Kadane scans.
//
// Channel   Direction  Ports                      Transaction
// s_        in         s_valid s_ready s_data     one sample, last marks end
// m_        out        m_valid m_ready m_data     one result per array
//
// The front stores one sample per cycle while s_ready is high and posts a job
// on the last sample. The backward pass over an array of n stored samples then
// steps the store read port from index n - 1 down to 1, with a queue hand-off
// and a pipeline drain, during all of which s_ready is low.
// A result waiting on m_ready does not stop the next array from loading.
// Reset is synchronous on aresetn low; the stores need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module max_abs_diff_two_subarrays #(
    parameter int MAX_LEN     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire mad_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output mad_pkg::out_t      m_data
);
    import mad_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = SAMPLE_BITS + AW + 1;

    logic                   wr_en;
    logic [AW-1:0]          wr_addr;
    logic [SAMPLE_BITS-1:0] wr_sample;
    logic signed [SW-1:0]   wr_min, wr_max;
    logic                   fq_valid, fq_ready, qb_valid, qb_ready;
    logic [CW:0]            fq_data, qb_data;
    logic                   back_busy, mem_busy;

    assign mem_busy = qb_valid || back_busy;

    mad_front #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .mem_busy  (mem_busy),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_sample (wr_sample),
        .wr_min    (wr_min),
        .wr_max    (wr_max),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job_data  (fq_data)
    );

    mad_queue #(
        .WIDTH (CW + 1),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_data   (fq_data),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_data  (qb_data)
    );

    mad_back #(
        .MAX_LEN     (MAX_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_sample (wr_sample),
        .wr_min    (wr_min),
        .wr_max    (wr_max),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job_data  (qb_data),
        .busy      (back_busy),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire

[design/mad_front.sv]
// ----------------------------------------------------------------------------
// mad_front
// Accepts samples, runs the forward Kadane scan, writes the sample and prefix
// stores and posts one job per array to the job queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mad_front #(
    parameter int MAX_LEN     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       s_valid,
    output logic                                            s_ready,
    input  wire mad_pkg::in_t                               s_data,
    input  wire logic                                       mem_busy,
    output logic                                            wr_en,
    output logic [$clog2(MAX_LEN)-1:0]                      wr_addr,
    output logic [SAMPLE_BITS-1:0]                          wr_sample,
    output logic signed [SAMPLE_BITS+$clog2(MAX_LEN):0]     wr_min,
    output logic signed [SAMPLE_BITS+$clog2(MAX_LEN):0]     wr_max,
    output logic                                            job_valid,
    input  wire logic                                       job_ready,
    output logic [$clog2(MAX_LEN+1):0]                      job_data
);
    import mad_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = SAMPLE_BITS + AW + 1;
    localparam int IW = (SAMPLE_BITS > SAMPLE_FIELD_W) ? SAMPLE_BITS : SAMPLE_FIELD_W;

    logic signed [SW-1:0] run_min_reg, run_max_reg, best_min_reg, best_max_reg;
    logic signed [SW-1:0] run_min_next, run_max_next, best_min_next, best_max_next;
    logic signed [SW-1:0] v, sum_min, sum_max;
    logic [IW-1:0]        raw_w;
    logic [CW-1:0]        count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic                 accept, full;

    always_comb begin
        raw_w   = IW'($unsigned(s_data.sample));
        v       = SW'(signed'(raw_w[SAMPLE_BITS-1:0]));
        s_ready = !mem_busy && job_ready;
        accept  = s_valid && s_ready;
        full    = (count_reg >= CW'(MAX_LEN));
        sum_min = run_min_reg + v;
        sum_max = run_max_reg + v;
        if (count_reg == '0) begin
            run_min_next  = v;
            run_max_next  = v;
            best_min_next = v;
            best_max_next = v;
        end else begin
            run_min_next  = (v < sum_min) ? v : sum_min;
            run_max_next  = (v > sum_max) ? v : sum_max;
            best_min_next = (best_min_reg < run_min_next) ? best_min_reg : run_min_next;
            best_max_next = (best_max_reg > run_max_next) ? best_max_reg : run_max_next;
        end
        count_next   = full ? count_reg : count_reg + CW'(1);
        dropped_next = dropped_reg || full;
        wr_en        = accept && !full;
        wr_addr      = count_reg[AW-1:0];
        wr_sample    = raw_w[SAMPLE_BITS-1:0];
        wr_min       = best_min_next;
        wr_max       = best_max_next;
        job_valid    = accept && s_data.last;
        job_data     = {count_next, dropped_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else if (accept) begin
            if (!full) begin
                run_min_reg  <= run_min_next;
                run_max_reg  <= run_max_next;
                best_min_reg <= best_min_next;
                best_max_reg <= best_max_next;
            end
            if (s_data.last) begin
                count_reg   <= '0;
                dropped_reg <= 1'b0;
            end else begin
                count_reg   <= count_next;
                dropped_reg <= dropped_next;
            end
        end
    end

endmodule

`default_nettype wire

[design/mad_queue.sv]
// ----------------------------------------------------------------------------
// mad_queue
// Small register queue that carries array jobs from the front to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mad_queue #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 2
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]    fill_reg;
    logic             push, pop;

    always_comb begin
        in_ready  = (fill_reg != NW'(DEPTH));
        out_valid = (fill_reg != '0);
        out_data  = entry_reg[rd_ptr_reg];
        push      = in_valid && in_ready;
        pop       = out_valid && out_ready;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + NW'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

[design/mad_back.sv]
// ----------------------------------------------------------------------------
// mad_back
// Holds the sample and prefix stores, runs the pipelined backward Kadane pass
// over one job and presents the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "max_abs_diff_two_subarrays_defines.svh"

module mad_back #(
    parameter int MAX_LEN     = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       wr_en,
    input  wire logic [$clog2(MAX_LEN)-1:0]                 wr_addr,
    input  wire logic [SAMPLE_BITS-1:0]                     wr_sample,
    input  wire logic signed [SAMPLE_BITS+$clog2(MAX_LEN):0] wr_min,
    input  wire logic signed [SAMPLE_BITS+$clog2(MAX_LEN):0] wr_max,
    input  wire logic                                       job_valid,
    output logic                                            job_ready,
    input  wire logic [$clog2(MAX_LEN+1):0]                 job_data,
    output logic                                            busy,
    output logic                                            m_valid,
    input  wire logic                                       m_ready,
    output mad_pkg::out_t                                   m_data
);
    import mad_pkg::*;

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int SW = SAMPLE_BITS + AW + 1;
    localparam int DW = SW + 1;
    localparam int MW = (DW > DIFF_FIELD_W) ? DW : DIFF_FIELD_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    logic [SAMPLE_BITS-1:0] sample_mem [MAX_LEN];
    logic signed [SW-1:0]   min_mem    [MAX_LEN];
    logic signed [SW-1:0]   max_mem    [MAX_LEN];

    state_t                 state_reg;
    logic [CW-1:0]          k_reg, n_reg, km1;
    logic                   dropped_reg;
    logic                   m_valid_reg;
    out_t                   m_data_reg;
    logic [SAMPLE_BITS-1:0] samp_q;
    logic signed [SW-1:0]   pmin_q, pmax_q, pmin2_reg, pmax2_reg;
    logic signed [SW-1:0]   rmin_reg, rmax_reg, smin_reg, smax_reg;
    logic signed [SW-1:0]   rmin_next, rmax_next, smin_next, smax_next;
    logic signed [SW-1:0]   v2, sum_min, sum_max;
    logic signed [DW-1:0]   d1, d2;
    logic [DW-1:0]          ad1, ad2, ad1_reg, ad2_reg, best_reg, best_next;
    logic [MW-1:0]          best_wide;
    logic                   s1_valid_reg, s1_first_reg, s2_valid_reg, s3_valid_reg;
    logic                   pipe_busy;
    logic [CW-1:0]          job_count;
    logic                   job_dropped;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            sample_mem[wr_addr] <= wr_sample;
            min_mem[wr_addr]    <= wr_min;
            max_mem[wr_addr]    <= wr_max;
        end
    end

    always_ff @(posedge aclk) begin
        samp_q <= sample_mem[k_reg[AW-1:0]];
        pmin_q <= min_mem[km1[AW-1:0]];
        pmax_q <= max_mem[km1[AW-1:0]];
    end

    always_comb begin
        km1         = k_reg - CW'(1);
        job_count   = job_data[CW:1];
        job_dropped = job_data[0];
        job_ready   = (state_reg == ST_IDLE);
        busy        = (state_reg == ST_RUN) || (state_reg == ST_DRAIN);
        pipe_busy   = s1_valid_reg || s2_valid_reg || s3_valid_reg;
        m_valid     = m_valid_reg;
        m_data      = m_data_reg;

        v2      = SW'(signed'(samp_q));
        sum_min = rmin_reg + v2;
        sum_max = rmax_reg + v2;
        if (s1_first_reg) begin
            rmin_next = v2;
            rmax_next = v2;
            smin_next = v2;
            smax_next = v2;
        end else begin
            rmin_next = (v2 < sum_min) ? v2 : sum_min;
            rmax_next = (v2 > sum_max) ? v2 : sum_max;
            smin_next = (smin_reg < rmin_next) ? smin_reg : rmin_next;
            smax_next = (smax_reg > rmax_next) ? smax_reg : rmax_next;
        end

        d1  = DW'(pmax2_reg) - DW'(smin_reg);
        d2  = DW'(pmin2_reg) - DW'(smax_reg);
        ad1 = (d1 < 0) ? $unsigned(-d1) : $unsigned(d1);
        ad2 = (d2 < 0) ? $unsigned(-d2) : $unsigned(d2);

        best_next = best_reg;
        if (ad1_reg > best_next) begin
            best_next = ad1_reg;
        end
        if (ad2_reg > best_next) begin
            best_next = ad2_reg;
        end
        best_wide = MW'(best_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_valid_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            k_reg        <= '0;
            n_reg        <= '0;
        end else begin
            s1_valid_reg <= (state_reg == ST_RUN);
            s1_first_reg <= (k_reg == n_reg - CW'(1));
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (s1_valid_reg) begin
                rmin_reg  <= rmin_next;
                rmax_reg  <= rmax_next;
                smin_reg  <= smin_next;
                smax_reg  <= smax_next;
                pmin2_reg <= pmin_q;
                pmax2_reg <= pmax_q;
            end
            if (s2_valid_reg) begin
                ad1_reg <= ad1;
                ad2_reg <= ad2;
            end
            if (s3_valid_reg) begin
                best_reg <= best_next;
            end
            if (m_valid_reg && m_ready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        n_reg       <= job_count;
                        dropped_reg <= job_dropped;
                        best_reg    <= '0;
                        k_reg       <= job_count - CW'(1);
                        if (job_count <= CW'(1)) begin
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_RUN;
                        end
                    end
                end
                ST_RUN: begin
                    if (k_reg == CW'(1)) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg - CW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (!pipe_busy) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg                <= 1'b1;
                        m_data_reg.best_difference <= best_wide[DIFF_FIELD_W-1:0];
                        m_data_reg.overflow        <= dropped_reg;
                        state_reg                  <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    `MAD_ASSERT_IMP(a_run_index, state_reg == ST_RUN, k_reg != '0 && k_reg < n_reg, "bad index")
    `MAD_ASSERT_NXT(a_pipe_flow, s2_valid_reg, s3_valid_reg, "pipeline stage lost an element")
    `MAD_ASSERT_IMP(a_done_empty, state_reg == ST_DONE, !pipe_busy, "result with stages busy")

endmodule

`default_nettype wire
